### hw/rtl/mmbd_pkg.sv
// mmbd_pkg: shared widths, register indexes, point and result types and the
// bucket flush ordering function of the min/max bucket decimator.
// No dependencies.
`timescale 1ns / 1ps

package mmbd_pkg;

  localparam int TIME_W = 48;
  localparam int VAL_W  = 32;
  localparam int BKT_W  = 13;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 48;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_BYPASS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ORIGIN = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SCALE  = 2'd2;

  typedef struct packed {
    logic        [TIME_W-1:0] tm;
    logic signed [VAL_W-1:0]  val;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic   run_end;
    logic   window_end;
  } result_t;

  typedef struct packed {
    point_t first;
    point_t second;
    logic   two;
  } flush_t;

  // order the low and high extremes by time, dropping an exact duplicate
  function automatic flush_t flush_pts(point_t lo, point_t hi);
    flush_t f;
    if (lo.tm <= hi.tm) begin
      f.first  = lo;
      f.second = hi;
      f.two    = (hi.tm != lo.tm) || (hi.val != lo.val);
    end else begin
      f.first  = hi;
      f.second = lo;
      f.two    = 1'b1;
    end
    return f;
  endfunction

endpackage

### hw/rtl/mmbd_bucket_idx.sv
// mmbd_bucket_idx: two-stage bucket index unit, floor(d * scale / 2^32)
// saturated at the last bucket. Depends on mmbd_pkg.
`timescale 1ns / 1ps

module mmbd_bucket_idx #(
  parameter int MAX_BUCKETS = 4096
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mmbd_pkg::TIME_W-1:0]  diff,
  input  logic [mmbd_pkg::TIME_W-1:0]  scale,
  output logic [mmbd_pkg::BKT_W-1:0]   idx
);
  import mmbd_pkg::*;

  localparam int LO_W  = 32;
  localparam int HI_W  = TIME_W - LO_W;
  localparam int PP_W  = TIME_W;
  localparam int SUM_W = PP_W + 1;
  localparam logic [SUM_W-1:0] SAT_Q = SUM_W'(MAX_BUCKETS - 1);
  localparam logic [BKT_W-1:0] SAT_IDX = BKT_W'(MAX_BUCKETS - 1);

  logic [HI_W-1:0] a1, b1;
  logic [LO_W-1:0] a0, b0;

  logic            hi_nz_r;
  logic [PP_W-1:0] m10_r, m01_r;
  logic [LO_W-1:0] m00_hi_r;
  logic [2*LO_W-1:0] m00;

  logic [SUM_W-1:0] q;
  logic [BKT_W-1:0] idx_r;

  assign a1  = diff[TIME_W-1:LO_W];
  assign a0  = diff[LO_W-1:0];
  assign b1  = scale[TIME_W-1:LO_W];
  assign b0  = scale[LO_W-1:0];
  assign m00 = a0 * b0;

  // stage one: partial products, the high-high term only matters as nonzero
  always_ff @(posedge clk) begin
    if (en) begin
      hi_nz_r  <= (a1 != '0) && (b1 != '0);
      m10_r    <= PP_W'(a1) * PP_W'(b0);
      m01_r    <= PP_W'(a0) * PP_W'(b1);
      m00_hi_r <= m00[2*LO_W-1:LO_W];
    end
  end

  // stage two: sum and saturate
  assign q = {1'b0, m10_r} + {1'b0, m01_r} + SUM_W'(m00_hi_r);

  always_ff @(posedge clk) begin
    if (en) begin
      if (hi_nz_r || (q >= SAT_Q)) begin
        idx_r <= SAT_IDX;
      end else begin
        idx_r <= q[BKT_W-1:0];
      end
    end
  end

  assign idx = idx_r;

endmodule

### hw/rtl/min_max_bucket_decimator.sv
// min_max_bucket_decimator: top level, input pipeline, bucket state and
// result buffer. Depends on mmbd_pkg and mmbd_bucket_idx.
//
// Usage:
//   Points (time, value) enter on the in_ stream in ascending time; in_tlast
//   marks the last point of a window. Each point is placed in a time bucket
//   and the earliest lowest and earliest highest point of each bucket leave
//   on the out_ stream when the bucket changes and at window end. out_tuser
//   flags the last result caused by one input point, out_tlast the final
//   result of a window. With bypass set every point passes through alone.
//   Registers are written through cfg_we / cfg_addr / cfg_wdata while idle.
// Registers from input accept to the first result on out_tvalid: the difference
//   register, partial products, index sum and result buffer.
// Throughput: one point per cycle; the three-entry result buffer drains one
//   result per cycle, so a point that produces results (up to 3) holds the
//   pipeline until the buffer is empty or its last result is being taken.
// Reset: synchronous, active low; clears the configuration registers, valid
//   flags, open bucket and result buffer. A stalled out_tready can hold the
//   pipeline while results wait; the presented result stays until it is taken.
`timescale 1ns / 1ps

module min_max_bucket_decimator #(
  parameter int MAX_BUCKETS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [mmbd_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [mmbd_pkg::CFG_DW-1:0]   cfg_wdata,
  // input points
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [79:0]                   in_tdata,   // point_time[47:0], point_value[79:48]
  input  logic                          in_tlast,   // window_last
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [79:0]                   out_tdata,  // out_time[47:0], out_value[79:48]
  output logic                          out_tuser,  // run_end
  output logic                          out_tlast   // window_end
);
  import mmbd_pkg::*;

  // configuration registers
  logic              bypass_r;
  logic [TIME_W-1:0] origin_r;
  logic [TIME_W-1:0] scale_r;

  // pipeline registers
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  logic [TIME_W-1:0] s1_diff_r;
  point_t            s1_pt_r, s2_pt_r, s3_pt_r;
  logic              s1_last_r, s2_last_r, s3_last_r;
  logic [BKT_W-1:0]  s3_idx;

  // bucket state
  logic              open_r;
  logic [BKT_W-1:0]  open_idx_r;
  point_t            lo_r, hi_r;

  // result buffer, entry 0 is presented
  result_t           bq_r [3];
  logic [1:0]        bcnt_r;

  point_t            in_pt;
  logic [TIME_W-1:0] in_diff;
  logic              advance, retire, load, pop, load_ok;
  logic              new_bkt;
  point_t            lo_nxt, hi_nxt;
  flush_t            fl_old, fl_new;
  logic [1:0]        n_old, n_new, k;
  point_t            e [3];
  result_t           bq_nxt [3];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      origin_r <= '0;
      scale_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BYPASS: bypass_r <= cfg_wdata[0];
        REG_ORIGIN: origin_r <= cfg_wdata[TIME_W-1:0];
        REG_SCALE:  scale_r  <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack and clamped time difference
  assign in_pt.tm  = in_tdata[TIME_W-1:0];
  assign in_pt.val = in_tdata[TIME_W+VAL_W-1:TIME_W];
  assign in_diff   = (in_pt.tm >= origin_r) ? (in_pt.tm - origin_r) : '0;

  // global pipeline stall
  assign pop       = out_tvalid && out_tready;
  assign load_ok   = (bcnt_r == 2'd0) || ((bcnt_r == 2'd1) && out_tready);
  assign retire    = s3_vld_r && ((k == 2'd0) || load_ok);
  assign advance   = !s3_vld_r || retire;
  assign load      = retire && (k != 2'd0);
  assign in_tready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_diff_r <= in_diff;
      s1_pt_r   <= in_pt;
      s1_last_r <= in_tlast;
      s2_pt_r   <= s1_pt_r;
      s2_last_r <= s1_last_r;
      s3_pt_r   <= s2_pt_r;
      s3_last_r <= s2_last_r;
    end
  end

  mmbd_bucket_idx #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_idx (
    .clk   (clk),
    .en    (advance),
    .diff  (s1_diff_r),
    .scale (scale_r),
    .idx   (s3_idx)
  );

  // bucket update and extremes of the updated bucket
  assign new_bkt = !open_r || (s3_idx != open_idx_r);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (new_bkt) begin
      lo_nxt = s3_pt_r;
      hi_nxt = s3_pt_r;
    end else begin
      if ($signed(s3_pt_r.val) < $signed(lo_r.val)) begin
        lo_nxt = s3_pt_r;
      end
      if ($signed(hi_r.val) < $signed(s3_pt_r.val)) begin
        hi_nxt = s3_pt_r;
      end
    end
  end

  assign fl_old = flush_pts(lo_r, hi_r);
  assign fl_new = flush_pts(lo_nxt, hi_nxt);
  assign n_old  = (open_r && new_bkt) ? (fl_old.two ? 2'd2 : 2'd1) : 2'd0;
  assign n_new  = s3_last_r ? (fl_new.two ? 2'd2 : 2'd1) : 2'd0;

  // gather the results of this item, old bucket first
  always_comb begin
    if (bypass_r) begin
      k    = 2'd1;
      e[0] = s3_pt_r;
      e[1] = s3_pt_r;
      e[2] = s3_pt_r;
    end else begin
      k    = n_old + n_new;
      e[0] = (n_old != 2'd0) ? fl_old.first : fl_new.first;
      priority case (n_old)
        2'd2:    e[1] = fl_old.second;
        2'd1:    e[1] = fl_new.first;
        default: e[1] = fl_new.second;
      endcase
      e[2] = fl_new.first;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bq_nxt[i].pt         = e[i];
      bq_nxt[i].run_end    = (2'(i) == k - 2'd1);
      bq_nxt[i].window_end = (2'(i) == k - 2'd1) && s3_last_r;
    end
  end

  // bucket state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (retire && !bypass_r) begin
      open_r <= !s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && !bypass_r) begin
      open_idx_r <= s3_idx;
      lo_r       <= lo_nxt;
      hi_r       <= hi_nxt;
    end
  end

  // result buffer: load a whole group or shift one out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 2'd0;
    end else if (load) begin
      bcnt_r <= k;
    end else if (pop) begin
      bcnt_r <= bcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bq_r <= bq_nxt;
    end else if (pop) begin
      bq_r[0] <= bq_r[1];
      bq_r[1] <= bq_r[2];
    end
  end

  // output port
  assign out_tvalid = (bcnt_r != 2'd0);
  assign out_tdata  = {bq_r[0].pt.val, bq_r[0].pt.tm};
  assign out_tuser  = bq_r[0].run_end;
  assign out_tlast  = bq_r[0].window_end;

endmodule
